// ===== hw/rtl/dtsp_pkg.sv =====
// ---------------------------------------------------------------------------
// dtsp_pkg
// Shared tokens, phase codes, event kinds and payload types of the
// devicetree structure block parser.
// ---------------------------------------------------------------------------
`default_nettype none

package dtsp_pkg;

    // Structure block tokens
    localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
    localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
    localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
    localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
    localparam logic [31:0] TOK_END        = 32'h0000_0009;

    // Parser phases
    localparam logic [2:0] PH_TOKEN = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_OFF   = 3'd3;
    localparam logic [2:0] PH_VALUE = 3'd4;
    localparam logic [2:0] PH_HALT  = 3'd5;

    // Event kinds
    localparam logic [3:0] KIND_CONSUMED  = 4'd0;
    localparam logic [3:0] KIND_NODE_BEGIN = 4'd1;
    localparam logic [3:0] KIND_NAME_WORD = 4'd2;
    localparam logic [3:0] KIND_PROP_HDR  = 4'd3;
    localparam logic [3:0] KIND_VALUE     = 4'd4;
    localparam logic [3:0] KIND_NODE_END  = 4'd5;
    localparam logic [3:0] KIND_TREE_END  = 4'd6;
    localparam logic [3:0] KIND_BAD_TOKEN = 4'd7;
    localparam logic [3:0] KIND_IGNORED   = 4'd8;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    typedef struct packed {
        logic [31:0] word;
        logic        first;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] data;
        logic [31:0] name_offset;
        logic [2:0]  valid_bytes;
        logic        last;
    } evt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtsp_in_if.sv =====
// ---------------------------------------------------------------------------
// dtsp_in_if
// Word channel into the parser: valid/ready plus one structure block word.
// ---------------------------------------------------------------------------
`default_nettype none

interface dtsp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        first;

    modport source (output valid, output word, output first, input ready);
    modport sink   (input valid, input word, input first, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dtsp_out_if.sv =====
// ---------------------------------------------------------------------------
// dtsp_out_if
// Event channel out of the parser: valid/ready plus one parse event.
// ---------------------------------------------------------------------------
`default_nettype none

interface dtsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] data;
    logic [31:0] name_offset;
    logic [2:0]  valid_bytes;
    logic        last;

    modport source (output valid, output kind, output data, output name_offset,
                    output valid_bytes, output last, input ready);
    modport sink   (input valid, input kind, input data, input name_offset,
                    input valid_bytes, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/devicetree_structure_parser_core.sv =====
// ---------------------------------------------------------------------------
// devicetree_structure_parser_core
// Flattened devicetree structure block parser: one event per input word.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                        | request
//  --------+-----+------------------------------------------------+-------------
//  words   | in  | word[31:0], first                              | one word
//  events  | out | kind[3:0], data[31:0], name_offset[31:0],      | one event
//          |     | valid_bytes[2:0], last                         |
//
//  One word per cycle sustained while events is not stalled; the event is decoded
//  from the input register and captured in the output register.
//  Rate is set by the single phase step between the two registers.
//  Reset puts the phase machine at "expect token" with zero byte counts.
//  A stalled output holds its event; the input register still fills, and
//  ready drops only while both registers are occupied and events is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module devicetree_structure_parser_core
    import dtsp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dtsp_in_if.sink     words,
    dtsp_out_if.source  events
);

    in_item_t in_item;
    in_item_t s1_item;
    logic     s1_valid;
    logic     s1_take;     // parser consumes the held word this cycle
    evt_t     step_evt;
    evt_t     out_evt;

    assign in_item = {words.word, words.first};

    // Input register
    dtsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (words.valid),
        .in_item    (in_item),
        .in_ready   (words.ready),
        .item_valid (s1_valid),
        .item       (s1_item),
        .take       (s1_take)
    );

    // Phase machine: state moves only when the event is captured downstream
    dtsp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_take),
        .item  (s1_item),
        .evt   (step_evt)
    );

    // Result register
    dtsp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid),
        .load_evt   (step_evt),
        .take       (s1_take),
        .out_valid  (events.valid),
        .out_evt    (out_evt),
        .out_ready  (events.ready)
    );

    assign events.kind        = out_evt.kind;
    assign events.data        = out_evt.data;
    assign events.name_offset = out_evt.name_offset;
    assign events.valid_bytes = out_evt.valid_bytes;
    assign events.last        = out_evt.last;

endmodule

`default_nettype wire

// ===== hw/rtl/dtsp_in_stage.sv =====
// ---------------------------------------------------------------------------
// dtsp_in_stage
// Input register: holds one accepted word until the parser consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module dtsp_in_stage
    import dtsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire in_item_t in_item,
    output logic          in_ready,
    output logic          item_valid,
    output in_item_t      item,
    input  wire logic     take
);

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dtsp_parser.sv =====
// ---------------------------------------------------------------------------
// dtsp_parser
// Phase machine and event decode; state advances on each consumed word.
// ---------------------------------------------------------------------------
`default_nettype none

module dtsp_parser
    import dtsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire in_item_t item,
    output evt_t          evt
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] saved_length_reg, saved_length_next;
    logic [2:0]  cur_phase;
    logic [2:0]  take_bytes;
    logic [31:0] w;

    assign w         = item.word;
    assign cur_phase = item.first ? PH_TOKEN : phase_reg;
    // min(bytes_left, 4)
    assign take_bytes = (bytes_left_reg < 32'd4) ? bytes_left_reg[2:0] : FULL_WORD_BYTES;

    always_comb
    begin
        phase_next        = cur_phase;
        bytes_left_next   = bytes_left_reg;
        saved_length_next = saved_length_reg;
        evt               = '0;
        unique case (cur_phase)
            PH_TOKEN:
            begin
                priority if (w == TOK_BEGIN_NODE)
                begin
                    phase_next = PH_NAME;
                    evt.kind   = KIND_NODE_BEGIN;
                end
                else if (w == TOK_PROP)
                begin
                    phase_next = PH_LEN;
                    evt.kind   = KIND_CONSUMED;
                end
                else if (w == TOK_END_NODE)
                    evt.kind = KIND_NODE_END;
                else if (w == TOK_NOP)
                    evt.kind = KIND_CONSUMED;
                else if (w == TOK_END)
                begin
                    phase_next = PH_HALT;
                    evt.kind   = KIND_TREE_END;
                end
                else
                begin
                    phase_next = PH_HALT;
                    evt.kind   = KIND_BAD_TOKEN;
                end
            end
            PH_NAME:
            begin
                evt.kind = KIND_NAME_WORD;
                evt.data = w;
                evt.last = 1'b1;
                // first zero byte, most significant byte first
                priority if (w[31:24] == 8'h00)
                    evt.valid_bytes = 3'd0;
                else if (w[23:16] == 8'h00)
                    evt.valid_bytes = 3'd1;
                else if (w[15:8] == 8'h00)
                    evt.valid_bytes = 3'd2;
                else if (w[7:0] == 8'h00)
                    evt.valid_bytes = 3'd3;
                else
                begin
                    evt.valid_bytes = FULL_WORD_BYTES;
                    evt.last        = 1'b0;
                end
                if (evt.last)
                    phase_next = PH_TOKEN;
            end
            PH_LEN:
            begin
                saved_length_next = w;
                phase_next        = PH_OFF;
                evt.kind          = KIND_CONSUMED;
            end
            PH_OFF:
            begin
                bytes_left_next = saved_length_reg;
                phase_next      = (saved_length_reg == 32'd0) ? PH_TOKEN : PH_VALUE;
                evt.kind        = KIND_PROP_HDR;
                evt.data        = saved_length_reg;
                evt.name_offset = w;
            end
            PH_VALUE:
            begin
                bytes_left_next = bytes_left_reg - {29'd0, take_bytes};
                evt.kind        = KIND_VALUE;
                evt.data        = w;
                evt.valid_bytes = take_bytes;
                evt.last        = (bytes_left_reg <= 32'd4);
                if (evt.last)
                    phase_next = PH_TOKEN;
            end
            default:
            begin
                phase_next = PH_HALT;
                evt.kind   = KIND_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TOKEN;
            bytes_left_reg   <= '0;
            saved_length_reg <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            saved_length_reg <= saved_length_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dtsp_out_stage.sv =====
// ---------------------------------------------------------------------------
// dtsp_out_stage
// Result register: captures an event whenever it is empty or being drained.
// ---------------------------------------------------------------------------
`default_nettype none

module dtsp_out_stage
    import dtsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load_valid,
    input  wire evt_t load_evt,
    output logic      take,
    output logic      out_valid,
    output evt_t      out_evt,
    input  wire logic out_ready
);

    logic valid_reg, valid_next;
    evt_t evt_reg;

    assign take      = load_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_evt   = evt_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            evt_reg <= load_evt;
    end

endmodule

`default_nettype wire

// ===== tb/sv/dtsp_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// dtsp_tb_pkg
// Expected-event tracking for the structure parser bench: a word-level
// model of the parse feeding an in-order event comparison.
// ---------------------------------------------------------------------------
package dtsp_tb_pkg;
    import dtsp_pkg::*;

    class parse_event_tracker;
        logic [2:0]  parse_phase;
        logic [31:0] bytes_left;
        logic [31:0] saved_len;
        evt_t        expected_events[$];
        int          mismatches;

        function new();
            parse_phase = PH_TOKEN;
            bytes_left  = '0;
            saved_len   = '0;
            mismatches  = 0;
        endfunction

        // Advance the parse by one word and return the event it produces.
        function evt_t parse_word(in_item_t item);
            evt_t       ev;
            logic [2:0] nb;
            bit         found;
            ev = '0;
            if (item.first)
            begin
                parse_phase = PH_TOKEN;
            end
            case (parse_phase)
                PH_TOKEN:
                begin
                    case (item.word)
                        TOK_BEGIN_NODE:
                        begin
                            parse_phase = PH_NAME;
                            ev.kind     = KIND_NODE_BEGIN;
                        end
                        TOK_PROP:
                        begin
                            parse_phase = PH_LEN;
                            ev.kind     = KIND_CONSUMED;
                        end
                        TOK_END_NODE: ev.kind = KIND_NODE_END;
                        TOK_NOP:      ev.kind = KIND_CONSUMED;
                        TOK_END:
                        begin
                            parse_phase = PH_HALT;
                            ev.kind     = KIND_TREE_END;
                        end
                        default:
                        begin
                            parse_phase = PH_HALT;
                            ev.kind     = KIND_BAD_TOKEN;
                        end
                    endcase
                end
                PH_NAME:
                begin
                    ev.kind        = KIND_NAME_WORD;
                    ev.data        = item.word;
                    ev.valid_bytes = FULL_WORD_BYTES;
                    found          = 1'b0;
                    // first zero byte from the MSB ends the name
                    for (int n = 0; n < 4; n++)
                    begin
                        if (!found && item.word[31-8*n -: 8] == 8'h00)
                        begin
                            found          = 1'b1;
                            ev.valid_bytes = n[2:0];
                            ev.last        = 1'b1;
                            parse_phase    = PH_TOKEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    saved_len   = item.word;
                    parse_phase = PH_OFF;
                    ev.kind     = KIND_CONSUMED;
                end
                PH_OFF:
                begin
                    bytes_left     = saved_len;
                    parse_phase    = (saved_len == '0) ? PH_TOKEN : PH_VALUE;
                    ev.kind        = KIND_PROP_HDR;
                    ev.data        = saved_len;
                    ev.name_offset = item.word;
                end
                PH_VALUE:
                begin
                    nb             = (bytes_left < 32'd4) ? bytes_left[2:0] : FULL_WORD_BYTES;
                    bytes_left     = bytes_left - 32'(nb);
                    ev.kind        = KIND_VALUE;
                    ev.data        = item.word;
                    ev.valid_bytes = nb;
                    if (bytes_left == '0)
                    begin
                        ev.last     = 1'b1;
                        parse_phase = PH_TOKEN;
                    end
                end
                default:
                begin
                    parse_phase = PH_HALT;
                    ev.kind     = KIND_IGNORED;
                end
            endcase
            return ev;
        endfunction

        function void note_word(in_item_t item);
            expected_events.push_back(parse_word(item));
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void flag(string what, evt_t exp, evt_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: exp kind=%0d data=%h off=%h vb=%0d last=%0d",
                         what, exp.kind, exp.data, exp.name_offset, exp.valid_bytes,
                         exp.last);
                $display("    got kind=%0d data=%h off=%h vb=%0d last=%0d",
                         got.kind, got.data, got.name_offset, got.valid_bytes, got.last);
            end
        endfunction

        function void check_event(evt_t got);
            evt_t  exp;
            string bad;
            if (expected_events.size() == 0)
            begin
                flag("event with none expected", '0, got);
                return;
            end
            exp = expected_events.pop_front();
            bad = "";
            if (got.kind !== exp.kind)               bad = {bad, " kind"};
            if (got.data !== exp.data)               bad = {bad, " data"};
            if (got.name_offset !== exp.name_offset) bad = {bad, " name_offset"};
            if (got.valid_bytes !== exp.valid_bytes) bad = {bad, " valid_bytes"};
            if (got.last !== exp.last)               bad = {bad, " last"};
            if (bad != "")
            begin
                flag({"mismatch in", bad}, exp, got);
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_devicetree_structure_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_devicetree_structure_parser_core
// Streams structure block words into the parser and checks every event
// in order against a word-level model of the parse, under varying
// backpressure on both channels.
// ---------------------------------------------------------------------------
module tb_devicetree_structure_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dtsp_pkg::*;
    import dtsp_tb_pkg::*;

    localparam int LATENCY     = 2;        // input reg + result reg
    localparam int LONG_HOLD   = 300;      // receiver hold-off, in cycles
    localparam int PHASE_WORDS = 360;      // fewest random words per random phase
    localparam int CYCLE_LIMIT = 200_000;  // far above the slowest legal run

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    dtsp_in_if  words_if ();
    dtsp_out_if events_if ();

    devicetree_structure_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .words  (words_if),
        .events (events_if)
    );

    parse_event_tracker evt_chk = new();

    in_item_t word_stream[$];   // requests for the current phase
    in_item_t tree_buf[$];      // one generated structure block
    bit       tree_first;       // next generated word opens a block
    bit       tree_cut;         // block abandoned, rest of tree skipped
    int       stall_pct;        // receiver stall rate, read by its process
    bit       hold_start;       // asks the receiver for a long hold-off

    // -----------------------------------------------------------------------
    // Stimulus generation
    // -----------------------------------------------------------------------

    function automatic void add(bit f, logic [31:0] w);
        in_item_t it;
        it.word  = w;
        it.first = f;
        word_stream.push_back(it);
    endfunction

    // Append a word to the block being built; the first one carries first=1.
    function automatic void put(logic [31:0] w);
        in_item_t it;
        it.word    = w;
        it.first   = tree_first;
        tree_first = 1'b0;
        tree_buf.push_back(it);
    endfunction

    // Zero to three full name words, then one with the terminator at a
    // random byte; bytes after the terminator are random.
    function automatic void gen_name();
        int          nfull;
        int          term;
        logic [31:0] w;
        nfull = $urandom_range(0, 3);
        for (int i = 0; i <= nfull; i++)
        begin
            term = (i == nfull) ? $urandom_range(0, 3) : 4;
            w    = $urandom();
            for (int b = 0; b < 4; b++)
            begin
                if (b < term)
                    w[31-8*b -: 8] = 8'($urandom_range(1, 255));
                else if (b == term)
                    w[31-8*b -: 8] = 8'h00;
            end
            put(w);
        end
    endfunction

    // Mostly short values; a few huge lengths that get cut off by a restart.
    function automatic void gen_prop();
        logic [31:0] len;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = $urandom_range(0, 16);
        else if (pick < 95)
            len = $urandom_range(17, 64);
        else
            len = $urandom() | 32'h8000_0000;
        put(TOK_PROP);
        put(len);
        put($urandom());
        if (pick >= 95)
        begin
            repeat ($urandom_range(1, 4)) put($urandom());
            tree_cut = 1'b1;
        end
        else
        begin
            repeat ((len + 3) / 4) put($urandom());
        end
    endfunction

    function automatic void gen_node(int depth);
        put(TOK_BEGIN_NODE);
        gen_name();
        repeat ($urandom_range(0, 3))
        begin
            if (tree_cut) return;
            if ($urandom_range(0, 4) == 0)
                put(TOK_NOP);
            else
                gen_prop();
        end
        if (depth < 2)
        begin
            repeat ($urandom_range(0, 2))
            begin
                if (tree_cut) return;
                gen_node(depth + 1);
            end
        end
        if (!tree_cut) put(TOK_END_NODE);
    endfunction

    // One block: mostly well formed, some pure noise, some cut short or
    // with a damaged word.
    function automatic void gen_tree();
        int       pick;
        in_item_t it;
        tree_buf.delete();
        tree_first = 1'b1;
        tree_cut   = 1'b0;
        pick       = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 5))
            begin
                it.word  = $urandom();
                it.first = $urandom_range(0, 1);
                tree_buf.push_back(it);
            end
        end
        else
        begin
            if ($urandom_range(0, 3) == 0) put(TOK_NOP);
            gen_node(0);
            if (!tree_cut)
            begin
                put(TOK_END);
                repeat ($urandom_range(0, 2)) put($urandom());  // trailing junk
            end
            if (pick >= 88 && tree_buf.size() > 1)
            begin
                tree_buf = tree_buf[0:$urandom_range(0, tree_buf.size() - 2)];
                if ($urandom_range(0, 1))
                    tree_buf[$urandom_range(0, tree_buf.size() - 1)].word = $urandom();
            end
        end
        foreach (tree_buf[i]) word_stream.push_back(tree_buf[i]);
    endfunction

    function automatic void build_random(int target);
        word_stream.delete();
        while (word_stream.size() < target) gen_tree();
    endfunction

    // Hand-picked block: every terminator position, empty and short
    // properties, a huge length abandoned by restart, restart inside a
    // name, end and bad tokens followed by ignored words.
    function automatic void build_directed();
        word_stream.delete();
        add(1, TOK_BEGIN_NODE);
        add(0, 32'h00FF_FFFF);        // empty root name, junk after zero
        add(0, TOK_BEGIN_NODE);
        add(0, 32'h6370_7573);        // four chars, no terminator
        add(0, 32'h4000_0000);        // one char
        add(0, TOK_BEGIN_NODE);
        add(0, 32'hFFFF_00FF);        // two chars
        add(0, TOK_PROP);
        add(0, 32'h0000_0000);        // empty property
        add(0, 32'hFFFF_FFFF);
        add(0, TOK_NOP);
        add(0, TOK_PROP);
        add(0, 32'h0000_0005);        // five bytes: 4 + 1
        add(0, 32'h0000_0000);
        add(0, 32'hFFFF_FFFF);
        add(0, 32'h1234_5678);
        add(0, TOK_END_NODE);
        add(0, TOK_BEGIN_NODE);
        add(1, TOK_BEGIN_NODE);       // restart while expecting a name
        add(0, 32'h4142_4300);        // three chars
        add(0, TOK_PROP);
        add(0, 32'hFFFF_FFFF);        // largest length
        add(0, 32'h0000_1234);
        add(0, 32'hAAAA_5555);
        add(0, 32'h0000_0000);
        add(1, TOK_END_NODE);         // restart in the middle of a value
        add(0, TOK_END);
        add(0, TOK_BEGIN_NODE);       // ignored after end
        add(1, 32'hFFFF_FFFF);        // bad token
        add(0, TOK_END);              // ignored after bad token
        add(1, 32'h0000_0000);        // zero is not a token either
    endfunction

    // -----------------------------------------------------------------------
    // Driving
    // -----------------------------------------------------------------------

    // Offer word_stream[from_idx..to_idx-1]. Payload is set at the rising
    // edge; the handshake is looked at on the falling edge, when valid and
    // ready are settled, and the request is taken at the next rising edge.
    task automatic send_items(int idle_pct, int from_idx, int to_idx);
        int idx;
        bit offering;
        idx      = from_idx;
        offering = 1'b0;
        @(posedge clk);
        while (idx < to_idx)
        begin
            if (!offering)
            begin
                if ($urandom_range(0, 99) >= idle_pct)
                begin
                    words_if.valid <= 1'b1;
                    words_if.word  <= word_stream[idx].word;
                    words_if.first <= word_stream[idx].first;
                    offering = 1'b1;
                end
                else
                begin
                    words_if.valid <= 1'b0;
                end
            end
            @(negedge clk);
            if (offering && words_if.ready)
            begin
                evt_chk.note_word(word_stream[idx]);
                idx++;
                offering = 1'b0;
            end
            @(posedge clk);
        end
        words_if.valid <= 1'b0;
    endtask

    // Wait until every event noted so far has come back.
    task automatic drain();
        while (evt_chk.pending() != 0) @(posedge clk);
    endtask

    // Event receiver: random stalls, plus a long hold-off on request that
    // it counts down itself.
    initial
    begin
        int hold_left;
        hold_left       = 0;
        events_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_left  = LONG_HOLD;
                hold_start = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                events_if.ready <= 1'b0;
            end
            else
            begin
                events_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Event monitor: same falling-edge sampling as the driver.
    initial
    begin
        evt_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && events_if.valid && events_if.ready)
            begin
                got = {events_if.kind, events_if.data, events_if.name_offset,
                       events_if.valid_bytes, events_if.last};
                evt_chk.check_event(got);
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int half;
        rst_n          = 1'b0;
        words_if.valid = 1'b0;
        words_if.word  = '0;
        words_if.first = 1'b0;
        stall_pct      = 0;
        hold_start     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed block, no idling
        build_directed();
        send_items(0, 0, word_stream.size());
        drain();

        // no idling; the receiver holds off long enough to back up the
        // input while the sender keeps offering
        build_random(PHASE_WORDS);
        stall_pct  = 0;
        hold_start = 1'b1;
        send_items(0, 0, word_stream.size());
        drain();

        // sender idles about half the time, with a full drain midway
        build_random(PHASE_WORDS);
        half = word_stream.size() / 2;
        send_items(49, 0, half);
        drain();
        send_items(49, half, word_stream.size());
        drain();

        // receiver stalls about half the time
        build_random(PHASE_WORDS);
        stall_pct = 49;
        send_items(0, 0, word_stream.size());
        drain();

        // light idling on both sides
        build_random(PHASE_WORDS);
        stall_pct = 6;
        send_items(6, 0, word_stream.size());
        drain();

        // let anything stray come out before judging
        repeat (4 * LATENCY) @(posedge clk);
        if (evt_chk.mismatches == 0 && evt_chk.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
